// ===== rtl/heart_rate_peak_tracker_unit_assert.svh =====
// assertion macros for the heart rate peak tracker
// used by heart_rate_peak_tracker_unit; expects i_clk and i_rst_n in scope
`ifndef HEART_RATE_PEAK_TRACKER_UNIT_ASSERT_SVH
`define HEART_RATE_PEAK_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define HRPT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define HRPT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrpt_pkg.sv =====
// shared types and constants of the heart rate peak tracker
// no dependencies; used by hrpt_muldiv and heart_rate_peak_tracker_unit
package hrpt_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MS_W       = 10;
    localparam int TICK_W     = 16;
    localparam int DIV_W      = 16;
    localparam int RATE_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd3;

    localparam int unsigned MS_PER_MIN  = 60000;
    localparam int unsigned RATE_MAX    = 1023;
    localparam int unsigned BASE_RESET  = 2048;
    localparam int unsigned MS_RESET    = 4;
    localparam int unsigned HOLD_RESET  = 50;
    localparam int unsigned DECAY_RESET = 100;

    typedef enum logic [2:0] {
        MODE_TRACK = 3'b001,
        MODE_HOLD  = 3'b010,
        MODE_DECAY = 3'b100
    } t_mode;

    typedef struct packed {
        logic start;
        logic rate_mode;
    } t_md_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

// ===== rtl/hrpt_muldiv.sv =====
// bit-serial multiply followed by a restoring divide, one bit per cycle
// depends on hrpt_pkg; rate mode divides 60000 by the clamped product instead
module hrpt_muldiv #(
    parameter int A_W = 26,
    parameter int B_W = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hrpt_pkg::t_md_ctrl       i_ctrl,
    input  logic [A_W-1:0]           i_mcand,
    input  logic [B_W-1:0]           i_mplier,
    input  logic [hrpt_pkg::DIV_W-1:0] i_divisor,
    output hrpt_pkg::t_md_stat       o_stat,
    output logic [A_W+B_W-1:0]       o_quot
);
    import hrpt_pkg::*;

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(P_W + 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } t_md_state;

    t_md_state          r_mstate;
    logic [P_W-1:0]     r_p;
    logic [A_W-1:0]     r_a;
    logic               r_rate;
    logic [DIV_W-1:0]   r_div;
    logic [DIV_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    logic [A_W-1:0]     addend;
    logic [A_W:0]       sum;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     trial_sub;
    logic               fits;
    logic               p_over;

    always_comb begin
        addend    = r_p[0] ? r_a : '0;
        sum       = {1'b0, r_p[P_W-1:B_W]} + {1'b0, addend};
        trial     = {r_rem, r_p[P_W-1]};
        trial_sub = trial - {1'b0, r_div};
        fits      = (trial >= {1'b0, r_div});
        p_over    = |r_p[P_W-1:DIV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            // pulse on the last divide step
            r_done <= (r_mstate == M_DIV) && (r_cnt == CNT_W'(1));
            case (r_mstate)
                M_IDLE: begin
                    if (i_ctrl.start) begin
                        r_p      <= P_W'(i_mplier);
                        r_a      <= i_mcand;
                        r_rate   <= i_ctrl.rate_mode;
                        r_div    <= i_divisor;
                        r_cnt    <= CNT_W'(B_W);
                        r_mstate <= M_MUL;
                    end
                end
                M_MUL: begin
                    if (r_cnt != '0) begin
                        // shift-add step, multiplier bits leave at the bottom
                        r_p   <= {sum, r_p[B_W-1:1]};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        if (r_rate) begin
                            // any period above 60000 gives zero, so clamp to 16 bits
                            r_div <= p_over ? '1 : r_p[DIV_W-1:0];
                            r_p   <= P_W'(MS_PER_MIN);
                        end
                        r_rem    <= '0;
                        r_cnt    <= CNT_W'(P_W);
                        r_mstate <= M_DIV;
                    end
                end
                M_DIV: begin
                    r_p   <= {r_p[P_W-2:0], fits};
                    r_rem <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_mstate <= M_IDLE;
                    end
                end
                default: begin
                    r_mstate <= M_IDLE;
                end
            endcase
        end
    end

    assign o_stat = {(r_mstate != M_IDLE), r_done};
    assign o_quot = r_p;

endmodule

// ===== rtl/heart_rate_peak_tracker_unit.sv =====
// top level of the heart rate peak tracker: threshold modes, peak timing, output register
// depends on hrpt_pkg, hrpt_muldiv and heart_rate_peak_tracker_unit_assert.svh
//
//  channel   dir  handshake                        word
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  sample, timestamp
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  rate_bpm, threshold; tuser peak_seen
//  cfg       in   i_cfg_valid/o_cfg_ready          register index and data
//
// a track-mode sample with no rate update, or one in the hold interval, goes through S_DEC
// and S_OUT into the output register; a peak with a rate update runs through the shared
// serial unit in S_WAIT, a decaying sample also through S_ABS before and S_FIN after it;
// the serial unit does a one-bit-per-cycle multiply and a full-width restoring divide
// one word is worked on at a time; the next is taken while the result waits in the output
// register; reset is synchronous and needs no clearing pass; config is always ready
`include "heart_rate_peak_tracker_unit_assert.svh"

module heart_rate_peak_tracker_unit #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // s_axis: sample [SAMPLE_BITS-1:0], timestamp above it, zero padding to bytes
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // m_axis: rate_bpm [10:0], threshold above it, zero padding to bytes
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    output logic [((hrpt_pkg::RATE_W+SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // m_axis tuser: peak_seen
    output logic o_m_axis_tuser,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [hrpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hrpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hrpt_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int TB    = TIME_BITS;
    localparam int DW    = TB + 2;
    localparam int MBW   = (SB > MS_W) ? SB : MS_W;
    localparam int PW    = DW + MBW;
    localparam int OUT_W = ((RATE_W + SB + 7) / 8) * 8;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_ABS  = 6'b000100,
        S_WAIT = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                    r_state;
    t_mode                     r_mode;
    logic [SB-1:0]             r_base;
    logic [MS_W-1:0]           r_ms;
    logic [TICK_W-1:0]         r_hold;
    logic [TICK_W-1:0]         r_decay;
    logic [SB-1:0]             r_cur;
    logic [SB-1:0]             r_peak;
    logic [SB-1:0]             r_prev;
    logic signed [TB:0]        r_lpt;
    logic signed [RATE_W-1:0]  r_rate;
    logic                      r_pvalid;

    logic [SB-1:0]             r_sample;
    logic [TB-1:0]             r_now;
    logic signed [DW-1:0]      r_diff;
    logic signed [DW-1:0]      r_x;
    logic signed [SB:0]        r_bp;
    logic                      r_neg;
    logic                      r_is_rate;
    logic                      r_seen;
    logic signed [PW:0]        r_qs;

    logic                      r_out_valid;
    logic signed [RATE_W-1:0]  r_out_rate;
    logic [SB-1:0]             r_out_thr;
    logic                      r_out_seen;

    logic                      in_acc;
    logic                      out_free;
    logic signed [DW-1:0]      hold_ext;
    logic                      is_peak;
    logic                      go_rate;
    logic [DW-1:0]             x_mag;
    logic [SB-1:0]             bp_mag;
    logic signed [PW+1:0]      t_val;
    logic signed [PW+1:0]      base_ext;
    logic signed [PW+1:0]      smax_ext;
    logic [PW-1:0]             quot;
    t_md_ctrl                  md_ctrl;
    t_md_stat                  md_stat;
    logic [DW-1:0]             md_mcand;
    logic [MBW-1:0]            md_mplier;
    logic [DIV_W-1:0]          md_divisor;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        hold_ext = $signed(DW'(r_hold));
        is_peak  = (r_mode == MODE_TRACK) && !(r_sample > r_cur) && (r_cur == r_prev);
        // rate only once an earlier peak exists and the period is positive
        go_rate  = is_peak && r_pvalid && !r_diff[DW-1] && (r_diff != '0) && (r_ms != '0);
        x_mag    = r_x[DW-1] ? DW'(-r_x) : DW'(r_x);
        bp_mag   = r_bp[SB] ? SB'(-r_bp) : SB'(r_bp);
        base_ext = $signed({1'b0, (PW+1)'(r_base)});
        smax_ext = $signed({1'b0, (PW+1)'({SB{1'b1}})});
        t_val    = $signed({1'b0, (PW+1)'(r_peak)}) + $signed({r_qs[PW], r_qs});

        md_ctrl.start     = (r_state == S_DEC && go_rate) || (r_state == S_ABS);
        md_ctrl.rate_mode = (r_state == S_DEC);
        md_mcand          = (r_state == S_DEC) ? DW'(r_diff) : x_mag;
        md_mplier         = (r_state == S_DEC) ? MBW'(r_ms) : MBW'(bp_mag);
        md_divisor        = (r_decay == '0) ? DIV_W'(1) : r_decay;
    end

    hrpt_muldiv #(
        .A_W (DW),
        .B_W (MBW)
    ) u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (md_ctrl),
        .i_mcand   (md_mcand),
        .i_mplier  (md_mplier),
        .i_divisor (md_divisor),
        .o_stat    (md_stat),
        .o_quot    (quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= SB'(BASE_RESET);
            r_ms    <= MS_W'(MS_RESET);
            r_hold  <= TICK_W'(HOLD_RESET);
            r_decay <= TICK_W'(DECAY_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data[SB-1:0];
                CFG_MS:    r_ms    <= i_cfg_data[MS_W-1:0];
                CFG_HOLD:  r_hold  <= i_cfg_data[TICK_W-1:0];
                CFG_DECAY: r_decay <= i_cfg_data[TICK_W-1:0];
                default:   r_base  <= r_base;
            endcase
        end
    end

    // output word valid: loaded from S_OUT, dropped when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_TRACK;
            r_cur       <= SB'(BASE_RESET);
            r_peak      <= '0;
            r_prev      <= '0;
            r_lpt       <= '0;
            r_rate      <= '1;
            r_pvalid    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= i_s_axis_tdata[SB-1:0];
                        r_now    <= i_s_axis_tdata[SB+TB-1:SB];
                        r_diff   <= $signed({2'b00, i_s_axis_tdata[SB+TB-1:SB]})
                                    - $signed({r_lpt[TB], r_lpt});
                        r_state  <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_seen    <= is_peak;
                    r_is_rate <= go_rate;
                    r_x       <= r_diff - hold_ext;
                    r_bp      <= $signed({1'b0, r_base}) - $signed({1'b0, r_peak});
                    if (go_rate) begin
                        r_state <= S_WAIT;
                    end else if ((r_mode == MODE_TRACK) || (r_mode == MODE_HOLD)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ABS;
                    end
                    case (r_mode)
                        MODE_TRACK: begin
                            if (r_sample > r_cur) begin
                                r_cur <= r_sample;
                            end else if (is_peak) begin
                                r_mode   <= MODE_HOLD;
                                r_peak   <= r_cur;
                                r_lpt    <= $signed({1'b0, r_now} - {{TB{1'b0}}, 1'b1});
                                r_pvalid <= 1'b1;
                            end
                        end
                        MODE_HOLD: begin
                            if (r_diff > hold_ext) begin
                                r_mode <= MODE_DECAY;
                            end
                        end
                        default: begin
                            r_mode <= r_mode;
                        end
                    endcase
                end
                S_ABS: begin
                    r_neg   <= r_x[DW-1] ^ r_bp[SB];
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (md_stat.done) begin
                        if (r_is_rate) begin
                            r_rate  <= (|quot[PW-1:RATE_W-1]) ? RATE_W'(RATE_MAX)
                                                              : $signed({1'b0, quot[RATE_W-2:0]});
                            r_state <= S_OUT;
                        end else begin
                            r_qs    <= r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    // decay ends at or below base, clips at the top of the sample range
                    if (t_val <= base_ext) begin
                        r_cur  <= r_base;
                        r_mode <= MODE_TRACK;
                    end else if (t_val > smax_ext) begin
                        r_cur <= {SB{1'b1}};
                    end else begin
                        r_cur <= t_val[SB-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_rate  <= r_rate;
                        r_out_thr   <= r_cur;
                        r_out_seen  <= r_seen;
                        r_prev      <= r_sample;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_thr, r_out_rate});
    assign o_m_axis_tuser  = r_out_seen;
    assign o_cfg_ready     = 1'b1;

    `HRPT_ASSERT_IMP(a_rate_range, r_out_valid, !r_out_rate[RATE_W-1] || (&r_out_rate), "rate below minus one")
    `HRPT_ASSERT_IMP(a_unit_busy, md_stat.busy, r_state == S_WAIT, "serial unit busy outside wait")
    `HRPT_ASSERT_IMP(a_peak_hold, (r_state == S_OUT) && r_seen, r_mode == MODE_HOLD, "peak without hold mode")
    `HRPT_ASSERT_NXT(a_out_load, (r_state == S_OUT) && out_free, r_out_valid, "result word not loaded")

endmodule

// ===== tb/heart_rate_peak_tracker_unit_tb.sv =====
// self-checking bench for heart_rate_peak_tracker_unit: pulse trains, noise and register sweeps
// depends on hrpt_pkg and the rtl of heart_rate_peak_tracker_unit; a scoreboard class predicts
// every result word and compares it with what leaves the master side
module heart_rate_peak_tracker_unit_tb;
    import hrpt_pkg::*;

    localparam int SAMPLE_W       = 12;
    localparam int TIME_W         = 24;
    localparam int SAMPLE_MAX     = 4095;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_WORDS    = 210;

    typedef struct {
        logic [10:0] rate;
        logic [11:0] level;
        logic        peak;
    } t_beat_word;

    class t_beat_scoreboard;
        // register copies
        longint base_level;
        longint ms_tick;
        longint hold_len;
        longint decay_len;
        // tracker state
        t_mode  mode;
        longint level;
        longint peak_level;
        longint prev_sample;
        longint last_peak;
        int     rate;
        bit     have_peak;

        t_beat_word expected_words[$];
        int failures;
        int samples;
        int words_checked;
        int peaks;
        int rate_updates;

        function new();
            base_level   = BASE_RESET;
            ms_tick      = MS_RESET;
            hold_len     = HOLD_RESET;
            decay_len    = DECAY_RESET;
            mode         = MODE_TRACK;
            level        = BASE_RESET;
            peak_level   = 0;
            prev_sample  = 0;
            last_peak    = 0;
            rate         = -1;
            have_peak    = 1'b0;
            failures     = 0;
            samples      = 0;
            words_checked = 0;
            peaks        = 0;
            rate_updates = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASE:  base_level = data[11:0];
                CFG_MS:    ms_tick    = data[9:0];
                CFG_HOLD:  hold_len   = data;
                CFG_DECAY: decay_len  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] ts);
            longint value;
            longint now;
            longint x;
            longint d;
            longint t;
            longint period;
            longint r;
            t_beat_word w;
            value  = s;
            now    = ts;
            w.peak = 1'b0;
            samples++;
            if (mode == MODE_TRACK) begin
                if (value > level) begin
                    level = value;
                end else if (level == prev_sample) begin
                    // previous sample was the top of the pulse
                    mode       = MODE_HOLD;
                    peak_level = level;
                    w.peak     = 1'b1;
                    peaks++;
                    if (have_peak) begin
                        period = (now - last_peak) * ms_tick;
                        if (period > 0) begin
                            r    = MS_PER_MIN / period;
                            rate = (r > RATE_MAX) ? RATE_MAX : int'(r);
                            rate_updates++;
                        end
                    end
                    last_peak = now - 1;
                    have_peak = 1'b1;
                end
            end else if (mode == MODE_HOLD) begin
                if (now - last_peak > hold_len) mode = MODE_DECAY;
            end else begin
                // linear fall toward base, truncated toward zero
                x = now - last_peak - hold_len;
                d = (decay_len == 0) ? 1 : decay_len;
                t = peak_level + (x * (base_level - peak_level)) / d;
                if (t <= base_level) begin
                    t    = base_level;
                    mode = MODE_TRACK;
                end else if (t > SAMPLE_MAX) begin
                    t = SAMPLE_MAX;
                end
                level = t;
            end
            prev_sample = value;
            w.rate  = rate[10:0];
            w.level = level[11:0];
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [10:0] rate_v, logic [11:0] level_v, logic peak_v);
            t_beat_word w;
            if (expected_words.size() == 0) begin
                $error("result word with no sample pending: rate_bpm %0d threshold %0d",
                       $signed(rate_v), level_v);
                failures++;
                return;
            end
            w = expected_words.pop_front();
            words_checked++;
            if (rate_v !== w.rate) begin
                $error("rate_bpm: expected %0d, got %0d", $signed(w.rate), $signed(rate_v));
                failures++;
            end
            if (level_v !== w.level) begin
                $error("threshold: expected %0d, got %0d", w.level, level_v);
                failures++;
            end
            if (peak_v !== w.peak) begin
                $error("peak_seen: expected %0b, got %0b", w.peak, peak_v);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_cfg_ready;

    t_beat_scoreboard beats;
    int          src_pct = 33;
    int          dst_pct = 70;
    int          settings = 0;
    int          idle_cycles = 0;
    int unsigned gen_time = 0;

    heart_rate_peak_tracker_unit #(
        .SAMPLE_BITS(SAMPLE_W),
        .TIME_BITS(TIME_W)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // result side: random backpressure, check on every accepted word
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready)
                beats.check_word(o_m_axis_tdata[10:0], o_m_axis_tdata[22:11], o_m_axis_tuser);
            m_tready <= ($urandom_range(0, 99) >= dst_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int sender_gap();
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_pct) gap++;
        return gap;
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] ts);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ts, s};
        do @(posedge clk); while (!o_s_axis_tready);
        beats.note_sample(s, ts);
    endtask

    // drop valid and wait for every outstanding result word
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (beats.pending() != 0);
    endtask

    task automatic load_regs(input logic [15:0] base_v, input logic [15:0] ms_v,
                             input logic [15:0] hold_v, input logic [15:0] decay_v);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_BASE, CFG_MS, CFG_HOLD, CFG_DECAY};
        vals = '{base_v, ms_v, hold_v, decay_v};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge clk); while (!o_cfg_ready);
            beats.write_reg(regs[k], vals[k]);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // triangle pulses on a running tick count, mixed with noise words
    task automatic run_phase(input int n_words, input int step_max, input int beat_len,
                             input bit pause_midway);
        int unsigned ph;
        int unsigned beat_idx;
        int          rise;
        int          lo;
        int          hi;
        int          val;
        logic [TIME_W-1:0] ts;
        rise     = beat_len / 8 + 1;
        lo       = $urandom_range(0, 1200);
        hi       = $urandom_range(int'(beats.base_level), SAMPLE_MAX);
        beat_idx = gen_time / beat_len;
        for (int i = 0; i < n_words; i++) begin
            if (pause_midway && i == n_words / 2) settle();
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 2))
                    0: begin
                        ts = TIME_W'($urandom());
                        gen_time = 32'(ts);
                    end
                    1: ts = TIME_W'(gen_time - $urandom_range(0, 5));
                    default: ts = TIME_W'(gen_time);
                endcase
                send_word(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), ts);
            end else begin
                gen_time = gen_time + $urandom_range(0, step_max);
                if (gen_time / beat_len != beat_idx) begin
                    beat_idx = gen_time / beat_len;
                    hi = $urandom_range(int'(beats.base_level), SAMPLE_MAX);
                end
                ph = gen_time % beat_len;
                if (hi < lo) hi = lo;
                if (ph < rise)
                    val = lo + (hi - lo) * int'(ph) / rise;
                else if (ph < 2 * rise)
                    val = lo + (hi - lo) * (2 * rise - int'(ph)) / rise;
                else
                    val = lo;
                val = val + $urandom_range(0, 3);
                if (val > SAMPLE_MAX) val = SAMPLE_MAX;
                send_word(val[SAMPLE_W-1:0], gen_time[TIME_W-1:0]);
            end
        end
    endtask

    initial begin
        beats = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rise, first peak, hold, decay, backwards time, end of decay
        send_word(12'd0, 24'd0);
        send_word(12'd4095, 24'd1);
        send_word(12'd4095, 24'd2);
        send_word(12'd0, 24'd10);
        send_word(12'd0, 24'd100);
        send_word(12'd0, 24'd120);
        send_word(12'd0, 24'd5);
        send_word(12'd0, 24'd400);
        send_word(12'd3000, 24'd401);
        send_word(12'd3000, 24'd402);
        send_word(12'd0, 24'h800000);
        send_word(12'd0, 24'hFFFFFF);

        // zero hold, zero decay length, fast and non-positive periods
        settle();
        load_regs(16'd0, 16'd1, 16'd0, 16'd0);
        send_word(12'd4095, 24'd10);
        send_word(12'd4095, 24'd11);
        send_word(12'd5, 24'd12);
        send_word(12'd5, 24'd13);
        send_word(12'd50, 24'd14);
        send_word(12'd50, 24'd15);
        send_word(12'd7, 24'd16);
        send_word(12'd7, 24'd17);
        send_word(12'd60, 24'd18);
        send_word(12'd60, 24'd14);

        for (int p = 0; p < 8; p++) begin
            src_pct = (p < 3) ? 33 : (p < 6) ? 70 : 0;
            dst_pct = (p < 3) ? 70 : (p < 6) ? 33 : 0;
            settle();
            case (p)
                0: load_regs(16'($urandom_range(1000, 3000)), 16'($urandom_range(1, 20)),
                             16'($urandom_range(0, 60)), 16'($urandom_range(1, 120)));
                1: load_regs(16'd0, 16'd1000, 16'd0, 16'd1);
                2: load_regs(16'd4095, 16'd1, 16'hFFFF, 16'hFFFF);
                3: load_regs(16'($urandom_range(0, SAMPLE_MAX)), 16'd0,
                             16'($urandom_range(0, 30)), 16'd0);
                4: load_regs(16'($urandom_range(0, SAMPLE_MAX)), 16'd1023,
                             16'($urandom_range(0, 30)), 16'($urandom_range(1, 60)));
                default: load_regs(16'($urandom_range(0, SAMPLE_MAX)),
                                   16'($urandom_range(1, 1000)),
                                   16'($urandom_range(0, 100)), 16'($urandom_range(1, 200)));
            endcase
            run_phase(PHASE_WORDS, $urandom_range(1, 6), $urandom_range(16, 300), p == 4);
        end

        settle();
        repeat (100) @(posedge clk);
        $display("checked %0d result words from %0d samples over %0d register settings",
                 beats.words_checked, beats.samples, settings + 1);
        $display("%0d peaks confirmed, %0d rate updates", beats.peaks, beats.rate_updates);
        if (beats.failures == 0 && beats.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
